// File: hdl/cdc_pkg.sv
// ----------------------------------------------------------------------------
// cdc_pkg: shared definitions for the calendar date counter
// Field widths, mode and status codes, controller states, command struct
// and month tables.
// ----------------------------------------------------------------------------
`default_nettype none

package cdc_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned CountW = 22;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned HundW  = 8;

  localparam logic [YearW-1:0] YearBaseReset = YearW'(1900);
  localparam logic [YearW-1:0] MaxYear       = YearW'(9999);
  localparam logic [YearW-1:0] ResetYear     = YearW'(1900);

  // y / 100 as (y * RecipMul) >> RecipShift, exact for 14-bit y
  localparam int unsigned RecipMul   = 5243;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned RecipProdW = 27;

  localparam logic [ModeW-1:0] ModeLoad    = 2'd0;
  localparam logic [ModeW-1:0] ModeNext    = 2'd1;
  localparam logic [ModeW-1:0] ModePrev    = 2'd2;
  localparam logic [ModeW-1:0] ModeCompare = 2'd3;

  localparam logic [StatW-1:0] StatOk        = 2'd0;
  localparam logic [StatW-1:0] StatBadLoad   = 2'd1;
  localparam logic [StatW-1:0] StatBelowBase = 2'd2;
  localparam logic [StatW-1:0] StatPastMax   = 2'd3;

  typedef enum logic [1:0] {
    StIdle,
    StLeap,
    StExec,
    StSum
  } cdc_state_e;

  typedef struct packed {
    logic capture;
    logic leap;
    logic exec;
    logic finish;
  } cdc_cmd_t;

  function automatic logic [DayW-1:0] days_in(input logic [MonW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the first of the month in a common year
  function automatic logic [DoyW-1:0] days_before(input logic [MonW-1:0] m);
    logic [DoyW-1:0] sum;
    case (m)
      4'd1:    sum = 9'd0;
      4'd2:    sum = 9'd31;
      4'd3:    sum = 9'd59;
      4'd4:    sum = 9'd90;
      4'd5:    sum = 9'd120;
      4'd6:    sum = 9'd151;
      4'd7:    sum = 9'd181;
      4'd8:    sum = 9'd212;
      4'd9:    sum = 9'd243;
      4'd10:   sum = 9'd273;
      4'd11:   sum = 9'd304;
      4'd12:   sum = 9'd334;
      default: sum = 9'd0;
    endcase
    return sum;
  endfunction

endpackage

`default_nettype wire

// File: hdl/cdc_ctrl.sv
// ----------------------------------------------------------------------------
// cdc_ctrl: sequencer of the calendar date counter
// Steps each item through capture, leap check, update and sum, and owns
// the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cdc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output cdc_pkg::cdc_cmd_t   cmd_o
);
  import cdc_pkg::*;

  cdc_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StLeap;
        end
      end
      StLeap: begin
        cmd_o.leap = 1'b1;
        state_d    = StExec;
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = StSum;
      end
      StSum: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: hdl/cdc_datapath.sv
// ----------------------------------------------------------------------------
// cdc_datapath: date registers and arithmetic of the calendar date counter
// Leap flags by reciprocal division, day step and load checks, ordinal day
// and day count, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cdc_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cdc_pkg::cdc_cmd_t              cmd_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [cdc_pkg::YearW-1:0]      cfg_wdata_i,
  input  wire logic [cdc_pkg::ModeW-1:0]      mode_i,
  input  wire logic [cdc_pkg::DayW-1:0]       in_day_i,
  input  wire logic [cdc_pkg::MonW-1:0]       in_month_i,
  input  wire logic [cdc_pkg::YearW-1:0]      in_year_i,
  output logic      [cdc_pkg::DayW-1:0]       cur_day_o,
  output logic      [cdc_pkg::MonW-1:0]       cur_month_o,
  output logic      [cdc_pkg::YearW-1:0]      cur_year_o,
  output logic      [cdc_pkg::DoyW-1:0]       day_of_year_o,
  output logic      [cdc_pkg::CountW-1:0]     day_count_o,
  output logic                                is_before_o,
  output logic                                is_same_o,
  output logic      [cdc_pkg::StatW-1:0]      status_o
);
  import cdc_pkg::*;

  function automatic logic [HundW-1:0] hundreds(input logic [YearW-1:0] y);
    logic [RecipProdW-1:0] prod;
    prod = RecipProdW'(y) * RecipProdW'(RecipMul);
    return prod[RecipShift +: HundW];
  endfunction

  function automatic logic leap_of(input logic [YearW-1:0] y, input logic [HundW-1:0] h);
    logic [YearW:0] back;
    logic           cent;
    back = (YearW+1)'(h) * (YearW+1)'(100);
    cent = (back == {1'b0, y});
    return (y[1:0] == 2'b00) && (!cent || (h[1:0] == 2'b00));
  endfunction

  logic [YearW-1:0] year_base_q;
  logic [DayW-1:0]  day_q, day_d;
  logic [MonW-1:0]  mon_q, mon_d;
  logic [YearW-1:0] year_q, year_d;

  logic [ModeW-1:0] mode_q;
  logic [DayW-1:0]  in_day_q;
  logic [MonW-1:0]  in_mon_q;
  logic [YearW-1:0] in_year_q;
  logic [YearW-1:0] prev_year_q;
  logic [HundW-1:0] h_in_q, h_cur_q, h_prev_q;
  logic             leap_in_q, leap_cur_q, leap_prev_q;

  logic             leap_new_q, leap_new_d;
  logic [StatW-1:0] stat_q, stat_d;
  logic             before_q, before_d;
  logic             same_q, same_d;

  logic [DayW-1:0]  dim_cur;
  logic [DayW-1:0]  dim_in;
  logic [DayW-1:0]  dim_back;
  logic             load_ok;

  logic [DoyW-1:0]   doy;
  logic [CountW-1:0] span;
  logic [YearW:0]    off;
  logic [YearW:0]    mag;
  logic [YearW-2:0]  quart;
  logic [CountW-1:0] quart_s;
  logic [CountW-1:0] count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_base_q <= YearBaseReset;
    end else if (cfg_we_i) begin
      year_base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q      <= mode_i;
      in_day_q    <= in_day_i;
      in_mon_q    <= in_month_i;
      in_year_q   <= in_year_i;
      prev_year_q <= year_q - YearW'(1);
      h_in_q      <= hundreds(in_year_i);
      h_cur_q     <= hundreds(year_q);
      h_prev_q    <= hundreds(year_q - YearW'(1));
    end
    if (cmd_i.leap) begin
      leap_in_q   <= leap_of(in_year_q, h_in_q);
      leap_cur_q  <= leap_of(year_q, h_cur_q);
      leap_prev_q <= leap_of(prev_year_q, h_prev_q);
    end
    if (cmd_i.exec) begin
      leap_new_q <= leap_new_d;
      stat_q     <= stat_d;
      before_q   <= before_d;
      same_q     <= same_d;
    end
  end

  assign dim_cur  = days_in(mon_q, leap_cur_q);
  assign dim_in   = days_in(in_mon_q, leap_in_q);
  assign dim_back = days_in(mon_q - MonW'(1), leap_cur_q);
  assign load_ok  = (in_year_q >= year_base_q) && (in_year_q <= MaxYear) &&
                    (in_mon_q >= MonW'(1)) && (in_mon_q <= MonW'(12)) &&
                    (in_day_q != '0) && (in_day_q <= dim_in);

  always_comb begin
    day_d      = day_q;
    mon_d      = mon_q;
    year_d     = year_q;
    leap_new_d = leap_cur_q;
    stat_d     = StatOk;
    before_d   = 1'b0;
    same_d     = 1'b0;
    case (mode_q)
      ModeLoad: begin
        if (load_ok) begin
          day_d      = in_day_q;
          mon_d      = in_mon_q;
          year_d     = in_year_q;
          leap_new_d = leap_in_q;
        end else begin
          stat_d = StatBadLoad;
        end
      end
      ModeNext: begin
        if (day_q < dim_cur) begin
          day_d = day_q + DayW'(1);
        end else if (mon_q < MonW'(12)) begin
          day_d = DayW'(1);
          mon_d = mon_q + MonW'(1);
        end else if (year_q >= MaxYear) begin
          stat_d = StatPastMax;
        end else begin
          day_d      = DayW'(1);
          mon_d      = MonW'(1);
          year_d     = year_q + YearW'(1);
          leap_new_d = 1'b0;
        end
      end
      ModePrev: begin
        if (day_q > DayW'(1)) begin
          day_d = day_q - DayW'(1);
        end else if (mon_q > MonW'(1)) begin
          mon_d = mon_q - MonW'(1);
          day_d = dim_back;
        end else if (year_q <= year_base_q) begin
          stat_d = StatBelowBase;
        end else begin
          year_d     = prev_year_q;
          mon_d      = MonW'(12);
          day_d      = DayW'(31);
          leap_new_d = leap_prev_q;
        end
      end
      ModeCompare: begin
        before_d = {year_q, mon_q, day_q} < {in_year_q, in_mon_q, in_day_q};
        same_d   = {year_q, mon_q, day_q} == {in_year_q, in_mon_q, in_day_q};
      end
      default: begin
        stat_d = StatOk;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q  <= DayW'(1);
      mon_q  <= MonW'(1);
      year_q <= ResetYear;
    end else if (cmd_i.exec) begin
      day_q  <= day_d;
      mon_q  <= mon_d;
      year_q <= year_d;
    end
  end

  // ordinal day and day count, truncating (year - 1901) / 4 toward zero
  assign doy     = days_before(mon_q) + DoyW'(day_q) +
                   DoyW'(leap_new_q && (mon_q > MonW'(2)));
  assign span    = CountW'((CountW'(year_q) - CountW'(1900)) * CountW'(365));
  assign off     = (YearW+1)'(year_q) - (YearW+1)'(1901);
  assign mag     = off[YearW] ? ((YearW+1)'(0) - off) : off;
  assign quart   = mag[YearW:2];
  assign quart_s = off[YearW] ? (CountW'(0) - CountW'(quart)) : CountW'(quart);
  assign count   = span + quart_s + CountW'(doy);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      cur_day_o     <= day_q;
      cur_month_o   <= mon_q;
      cur_year_o    <= year_q;
      day_of_year_o <= doy;
      day_count_o   <= count;
      is_before_o   <= before_q;
      is_same_o     <= same_q;
      status_o      <= stat_q;
    end
  end

endmodule

`default_nettype wire

// File: hdl/calendar_date_counter_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_counter_unit: Gregorian date register with day stepping
// Load, next day, previous day and compare on one stored date; each item
// returns the date, its ordinal day and its day count.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i / in_ready_o  mode, in_day, in_month, in_year
//   out       output     out_valid_o / out_ready_i cur_*, day_of_year, day_count,
//                                                  is_before, is_same, status
//   cfg       input      cfg_we_i                 cfg_wdata_i (year_base)
//
// an item steps through capture with the divide-by-100 products, leap
// flags, date update, ordinal day and day count into the output register
// in_ready_o is high only while the sequencer is idle
// the next item is taken while a result waits; it stalls in its last step
// until the output register is free
// reset sets the date to 1 january 1900 and year_base to 1900
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_counter_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cdc_pkg::YearW-1:0]      cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [cdc_pkg::ModeW-1:0]      mode_i,
  input  wire logic [cdc_pkg::DayW-1:0]       in_day_i,
  input  wire logic [cdc_pkg::MonW-1:0]       in_month_i,
  input  wire logic [cdc_pkg::YearW-1:0]      in_year_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [cdc_pkg::DayW-1:0]       cur_day_o,
  output logic      [cdc_pkg::MonW-1:0]       cur_month_o,
  output logic      [cdc_pkg::YearW-1:0]      cur_year_o,
  output logic      [cdc_pkg::DoyW-1:0]       day_of_year_o,
  output logic      [cdc_pkg::CountW-1:0]     day_count_o,
  output logic                                is_before_o,
  output logic                                is_same_o,
  output logic      [cdc_pkg::StatW-1:0]      status_o
);
  import cdc_pkg::*;

  cdc_cmd_t cmd;

  cdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  cdc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mode_i        (mode_i),
    .in_day_i      (in_day_i),
    .in_month_i    (in_month_i),
    .in_year_i     (in_year_i),
    .cur_day_o     (cur_day_o),
    .cur_month_o   (cur_month_o),
    .cur_year_o    (cur_year_o),
    .day_of_year_o (day_of_year_o),
    .day_count_o   (day_count_o),
    .is_before_o   (is_before_o),
    .is_same_o     (is_same_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire

// File: hdl/cdc_checker.sv
// ----------------------------------------------------------------------------
// cdc_checker: port-level checks for the calendar date counter
// Handshake stability, one item in flight, sane delivered dates and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module cdc_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           cfg_we_i,
  input wire logic [cdc_pkg::YearW-1:0]      cfg_wdata_i,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic [cdc_pkg::ModeW-1:0]      mode_i,
  input wire logic [cdc_pkg::DayW-1:0]       in_day_i,
  input wire logic [cdc_pkg::MonW-1:0]       in_month_i,
  input wire logic [cdc_pkg::YearW-1:0]      in_year_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [cdc_pkg::DayW-1:0]       cur_day_o,
  input wire logic [cdc_pkg::MonW-1:0]       cur_month_o,
  input wire logic [cdc_pkg::YearW-1:0]      cur_year_o,
  input wire logic [cdc_pkg::DoyW-1:0]       day_of_year_o,
  input wire logic [cdc_pkg::CountW-1:0]     day_count_o,
  input wire logic                           is_before_o,
  input wire logic                           is_same_o,
  input wire logic [cdc_pkg::StatW-1:0]      status_o
);
  import cdc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cur_day_o) &&
      $stable(cur_month_o) && $stable(cur_year_o) && $stable(day_of_year_o) &&
      $stable(day_count_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  a_date_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cur_month_o >= MonW'(1) && cur_month_o <= MonW'(12) &&
      cur_day_o != '0 && day_of_year_o != '0 && day_of_year_o <= DoyW'(366))
    else $error("delivered date out of range");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_before_o && is_same_o) &&
      (status_o == StatOk || (!is_before_o && !is_same_o)))
    else $error("compare flags inconsistent");

endmodule

bind calendar_date_counter_unit cdc_checker u_cdc_checker (.*);

`default_nettype wire
